FILE: hw/rtl/lkv_pkg.sv
// Shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	localparam int REG_CAPACITY = 0;

	typedef struct packed {
		logic                  operation;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_UPDATE,
		ST_DONE
	} seq_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lkv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative key-value cache with LRU replacement.
// Usage:
//   Requests arrive on req (valid/ready): a lookup or a store of a key/value.
//   Each request gives exactly one response on rsp (valid/ready), in order.
//   The capacity register sits at APB address 0; writing it empties the cache.
//   Write it only while no request is in flight.
// Sequence:
//   One shared key/rank comparator walks the entries one per cycle, fed from
//   the key and rank RAMs. A request takes a scan pass, a decision state
//   (ST_PICK), a rank update pass (skipped on a lookup miss) and a state that
//   loads the response register once it is free. req_ready is high only while
//   the sequencer is idle, so one request is in work at a time.
// Reset:
//   arst_n clears all valid bits, occupancy and the response valid flag and
//   sets capacity to min(ENTRIES, 16). No clearing pass is needed.
// Stall:
//   The response register holds until taken; a new request may be accepted
//   meanwhile, and its finished result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lkv_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output lkv_pkg::rsp_t      rsp
);

	import lkv_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PTR_W = IDX_W + 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CAP_BITS-1:0] CAP_RST = CAP_BITS'((ENTRIES < 16) ? ENTRIES : 16);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	seq_state_t state_q, state_d;

	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    occ_q;
	logic [CAP_BITS-1:0] cap_q;

	req_t                req_q;
	logic [PTR_W-1:0]    ptr_q;
	logic                chk_vld_s1;
	logic [IDX_W-1:0]    chk_idx_s1;

	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [IDX_W-1:0]    hit_rank_q;
	logic                lru_found_q;
	logic [IDX_W-1:0]    lru_idx_q;
	logic [KEY_BITS-1:0] lru_key_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    thresh_q;
	logic                age_all_q;
	logic                res_found_q;
	logic                res_rd_hit_q;
	logic                res_evicted_q;
	logic [KEY_BITS-1:0] res_ev_key_q;

	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] value_rd;
	logic [IDX_W-1:0]      rank_rd;

	// APB decode
	logic                cfg_wr;
	logic                cfg_hit;
	logic [CAP_BITS-1:0] cap_wr;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr == 3'(REG_CAPACITY * 4));
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? 32'(cap_q) : 32'd0;

	always_comb begin
		cap_wr = pwdata[CAP_BITS-1:0];
		if (cap_wr == '0) begin
			cap_wr = CAP_BITS'(1);
		end else if (32'(cap_wr) > 32'(ENTRIES)) begin
			cap_wr = CAP_BITS'(ENTRIES);
		end
	end

	// Shared compare unit: one entry per cycle
	logic             walking;
	logic             pass_end;
	logic             cur_valid;
	logic             key_match;
	logic             lru_match;
	logic             rank_older;

	assign walking    = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
	assign pass_end   = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);
	assign cur_valid  = valid_q[chk_idx_s1];
	assign key_match  = cur_valid && (key_rd == req_q.key);
	assign lru_match  = cur_valid && (occ_q != '0) &&
		(CNT_W'(rank_rd) == (occ_q - CNT_W'(1)));
	assign rank_older = rank_rd < thresh_q;

	// Decision terms
	logic             is_store;
	logic             at_capacity;
	logic             do_evict;
	logic             do_insert;
	logic             do_rank;
	logic [IDX_W-1:0] slot_d;

	assign is_store    = (req_q.operation == OP_STORE);
	assign at_capacity = (32'(occ_q) >= 32'(cap_q)) && (occ_q != '0);
	assign do_evict    = is_store && !hit_q && at_capacity && lru_found_q;
	assign do_insert   = is_store && !hit_q && (do_evict || free_found_q);
	assign do_rank     = hit_q || do_insert;
	assign slot_d      = hit_q ? hit_idx_q : (do_evict ? lru_idx_q : free_idx_q);

	// RAM controls
	logic             key_we;
	logic             val_we;
	logic             rank_we;
	logic [IDX_W-1:0] rank_wdata;
	logic             rank_slot;

	assign key_we    = (state_q == ST_PICK) && do_insert;
	assign val_we    = (state_q == ST_PICK) && (do_insert || (hit_q && is_store));
	assign rank_slot = (chk_idx_s1 == slot_q);
	assign rank_we   = (state_q == ST_UPDATE) && chk_vld_s1 &&
		(rank_slot || (cur_valid && (age_all_q || rank_older)));
	assign rank_wdata = rank_slot ? '0 : IDX_W'(rank_rd + IDX_W'(1));

	lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (slot_d),
		.wdata (req_q.key),
		.re    (1'b1),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (key_rd)
	);

	lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (slot_d),
		.wdata (req_q.value),
		.re    (state_q == ST_PICK),
		.raddr (hit_idx_q),
		.rdata (value_rd)
	);

	lkv_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (chk_idx_s1),
		.wdata (rank_wdata),
		.re    (1'b1),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (rank_rd)
	);

	// Sequencer
	logic rsp_load;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pass_end) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				state_d = do_rank ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE: begin
				if (pass_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			cap_q       <= CAP_RST;
			ptr_q       <= '0;
			chk_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q   <= cap_wr;
				valid_q <= '0;
				occ_q   <= '0;
			end else if (state_q == ST_PICK && do_insert) begin
				valid_q[slot_d] <= 1'b1;
				if (!do_evict) begin
					occ_q <= occ_q + CNT_W'(1);
				end
			end

			// advance the walk pointer; restart it before each pass
			if (state_q == ST_IDLE || state_q == ST_PICK) begin
				ptr_q <= '0;
			end else if (walking && ptr_q < PTR_W'(ENTRIES)) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			chk_vld_s1 <= walking && (ptr_q < PTR_W'(ENTRIES));

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload and scan results
	always_ff @(posedge clk) begin
		chk_idx_s1 <= ptr_q[IDX_W-1:0];

		if (req_valid && req_ready) begin
			req_q        <= req;
			hit_q        <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end

		if (state_q == ST_SCAN && chk_vld_s1) begin
			if (key_match && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= chk_idx_s1;
				hit_rank_q <= rank_rd;
			end
			if (lru_match && !lru_found_q) begin
				lru_found_q <= 1'b1;
				lru_idx_q   <= chk_idx_s1;
				lru_key_q   <= key_rd;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= chk_idx_s1;
			end
		end

		if (state_q == ST_PICK) begin
			slot_q        <= slot_d;
			thresh_q      <= hit_rank_q;
			age_all_q     <= !hit_q;
			res_found_q   <= hit_q;
			res_rd_hit_q  <= hit_q && !is_store;
			res_evicted_q <= do_evict;
			res_ev_key_q  <= do_evict ? lru_key_q : '0;
		end

		if (rsp_load) begin
			rsp_q.found       <= res_found_q;
			rsp_q.read_value  <= res_rd_hit_q ? value_rd : '0;
			rsp_q.evicted     <= res_evicted_q;
			rsp_q.evicted_key <= res_ev_key_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lkv_checker.sv
// Port-level checks of the LRU key-value cache and their binding.
`timescale 1ns / 1ps
`default_nettype none
module lkv_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire lkv_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire lkv_pkg::rsp_t rsp
);

	import lkv_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in work at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.read_value == '0) || rsp.found)
		else $error("read value without hit");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> !rsp.found)
		else $error("eviction on a hit");

	a_evkey_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |-> rsp.evicted_key == '0)
		else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);
`default_nettype wire

FILE: tb/tb_lru_key_value_cache_unit.sv
// Self-checking testbench for the LRU key-value cache: scoreboard, drivers, and checks.
`timescale 1ns / 1ps
module tb_lru_key_value_cache_unit;
	import lkv_pkg::*;

	localparam int ENTRIES      = 16;
	localparam int REG_UNUSED   = 1;
	localparam int LATENCY_WAIT = 2 * ENTRIES + 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASES       = 9;

	class cache_scoreboard;
		bit                    line_valid [ENTRIES];
		logic [KEY_BITS-1:0]   line_key   [ENTRIES];
		logic [VALUE_BITS-1:0] line_data  [ENTRIES];
		logic [3:0]            line_age   [ENTRIES];
		logic [4:0]            fill_count;
		logic [4:0]            capacity;
		rsp_t                  expected_rsp_q [$];
		int                    errors;
		int                    hits;
		int                    evictions;
		int                    requests;

		function new();
			errors    = 0;
			hits      = 0;
			evictions = 0;
			requests  = 0;
			capacity  = 5'(ENTRIES);
			flush();
		endfunction

		function void flush();
			for (int i = 0; i < ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_key[i]   = '0;
				line_data[i]  = '0;
				line_age[i]   = '0;
			end
			fill_count = '0;
		endfunction

		function void write_reg(int unsigned index, logic [31:0] data);
			logic [4:0] cap;
			cap = data[4:0];
			if (index != REG_CAPACITY)
				return;
			if (cap == 0)
				cap = 5'd1;
			if (cap > ENTRIES)
				cap = 5'(ENTRIES);
			capacity = cap;
			flush();
		endfunction

		function int pending();
			return expected_rsp_q.size();
		endfunction

		function void note_request(req_t r);
			int   hit;
			int   slot;
			rsp_t e;
			hit  = -1;
			slot = -1;
			e    = '0;
			requests++;
			for (int i = 0; i < ENTRIES; i++)
				if (hit < 0 && line_valid[i] && line_key[i] == r.key)
					hit = i;
			if (hit >= 0) begin
				e.found = 1'b1;
				hits++;
				if (r.operation == OP_LOOKUP)
					e.read_value = line_data[hit];
				else
					line_data[hit] = r.value;
				// age every entry that was newer than the hit one
				for (int i = 0; i < ENTRIES; i++)
					if (line_valid[i] && i != hit && line_age[i] < line_age[hit])
						line_age[i]++;
				line_age[hit] = '0;
			end else if (r.operation == OP_STORE) begin
				if (fill_count >= capacity && fill_count > 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && line_valid[i] && 5'(line_age[i]) == fill_count - 5'd1)
							slot = i;
					if (slot >= 0) begin
						e.evicted     = 1'b1;
						e.evicted_key = line_key[slot];
						line_valid[slot] = 1'b0;
						fill_count--;
						evictions++;
					end
				end
				if (slot < 0)
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !line_valid[i])
							slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (line_valid[i])
							line_age[i]++;
					line_valid[slot] = 1'b1;
					line_key[slot]   = r.key;
					line_data[slot]  = r.value;
					line_age[slot]   = '0;
					fill_count++;
				end
			end
			expected_rsp_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected response: found=%0d read_value=%h evicted=%0d evicted_key=%h",
					got.found, got.read_value, got.evicted, got.evicted_key);
				errors++;
				return;
			end
			e = expected_rsp_q.pop_front();
			if (got.found !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, got.found);
				errors++;
			end
			if (got.read_value !== e.read_value) begin
				$error("read_value: expected %h, actual %h", e.read_value, got.read_value);
				errors++;
			end
			if (got.evicted !== e.evicted) begin
				$error("evicted: expected %0d, actual %0d", e.evicted, got.evicted);
				errors++;
			end
			if (got.evicted_key !== e.evicted_key) begin
				$error("evicted_key: expected %h, actual %h", e.evicted_key, got.evicted_key);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;

	cache_scoreboard sb;
	bit              steady;
	int              next_gap;
	int              cycle_count;
	int              settings_used;
	logic [15:0]     key_pool [24];
	int              pool_size;

	lru_key_value_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic int pick_gap();
		if (steady || $urandom_range(0, 99) >= 33)
			return 0;
		return $urandom_range(1, 40);
	endfunction

	task automatic send_req(input logic op, input logic [15:0] k, input logic [31:0] v);
		if (next_gap > 0)
			repeat (next_gap) @(posedge clk);
		req_valid <= 1'b1;
		req       <= '{operation: op, key: k, value: v};
		do @(posedge clk); while (!req_ready);
		// drop valid now only if the next transfer waits; else keep it high
		next_gap = pick_gap();
		if (next_gap > 0)
			req_valid <= 1'b0;
	endtask

	task automatic drain();
		if (next_gap == 0)
			req_valid <= 1'b0;
		next_gap = 0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic apb_write(input int unsigned index, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(index * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(index, data);
		if (index == REG_CAPACITY)
			settings_used++;
	endtask

	task automatic run_phase(input logic [31:0] cap_word, input int count);
		int          ecap;
		logic        op;
		logic [15:0] k;
		ecap = (cap_word[4:0] == 0) ? 1 : ((cap_word[4:0] > ENTRIES) ? ENTRIES : cap_word[4:0]);
		apb_write(REG_CAPACITY, cap_word);
		pool_size = ecap + $urandom_range(1, 6);
		if (pool_size > 24)
			pool_size = 24;
		for (int i = 0; i < 24; i++)
			key_pool[i] = 16'($urandom);
		for (int n = 0; n < count; n++) begin
			// mid-phase write to an unmapped register must leave the contents alone
			if (n == count / 2) begin
				drain();
				apb_write(REG_UNUSED, $urandom);
			end
			op = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
			if ($urandom_range(0, 99) < 90)
				k = key_pool[$urandom_range(0, pool_size - 1)];
			else
				k = 16'($urandom);
			send_req(op, k, $urandom);
		end
		drain();
	endtask

	initial begin
		logic [31:0] phase_caps [PHASES];
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_valid     = 1'b0;
		req           = '0;
		steady        = 1'b0;
		next_gap      = 0;
		settings_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default capacity: extremes of key and value, update and miss
		send_req(OP_STORE, 16'h0000, 32'h0000_0000);
		send_req(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(OP_LOOKUP, 16'h0000, 32'h0000_0000);
		send_req(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
		send_req(OP_LOOKUP, 16'h1234, 32'h0000_0000);
		send_req(OP_STORE, 16'h0000, 32'hA5A5_5A5A);
		send_req(OP_LOOKUP, 16'h0000, 32'h0000_0000);
		send_req(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
		drain();
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_req(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
		drain();

		// capacity two: a lookup refreshes recency, so the other entry goes
		apb_write(REG_CAPACITY, 32'd2);
		send_req(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
		send_req(OP_STORE, 16'h0001, 32'h0000_0011);
		send_req(OP_STORE, 16'h0002, 32'h0000_0022);
		send_req(OP_LOOKUP, 16'h0001, 32'h0000_0000);
		send_req(OP_STORE, 16'h0003, 32'h0000_0033);
		send_req(OP_LOOKUP, 16'h0002, 32'h0000_0000);
		send_req(OP_LOOKUP, 16'h0003, 32'h0000_0000);
		drain();

		// zero capacity behaves as one
		apb_write(REG_CAPACITY, 32'd0);
		send_req(OP_STORE, 16'h0005, 32'h5555_5555);
		send_req(OP_STORE, 16'h0006, 32'h6666_6666);
		send_req(OP_STORE, 16'h0006, 32'hAAAA_AAAA);
		drain();

		// upper data bits are ignored; this lands on full capacity
		apb_write(REG_CAPACITY, 32'hFFFF_FFF0);
		send_req(OP_STORE, 16'h0007, 32'h7777_7777);
		send_req(OP_LOOKUP, 16'h0007, 32'h0000_0000);
		drain();

		phase_caps = '{32'd16, 32'd1, 32'd31, 32'd3, 32'd0, 32'd8, 32'd17, 32'd2,
			32'($urandom_range(1, 16))};
		for (int p = 0; p < PHASES; p++) begin
			steady = (p == 2);
			run_phase(phase_caps[p], RANDOM_ITEMS / PHASES);
		end
		steady = 1'b0;

		$display("Ran %0d requests over %0d capacity settings with random stalls on both sides.",
			sb.requests, settings_used);
		$display("Saw %0d hits and %0d evictions.", sb.hits, sb.evictions);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_ram.sv
hw/rtl/lru_key_value_cache_unit.sv
hw/rtl/lkv_checker.sv
tb/tb_lru_key_value_cache_unit.sv
